// File: hw/rtl/ucd_pkg.sv
// Shared types, constants and the microprogram for the Unix time to calendar date converter.
`timescale 1ns / 1ps

package ucd_pkg;

  localparam int PC_W = 5;

  localparam logic [11:0] EPOCH_YEAR      = 12'd1970;
  localparam logic [11:0] NONLEAP_CENTURY = 12'd2100;
  localparam logic [3:0]  FIRST_MONTH     = 4'd1;
  localparam logic [3:0]  LAST_MONTH      = 4'd12;
  localparam logic [8:0]  DAYS_COMMON     = 9'd365;
  localparam logic [8:0]  DAYS_LEAP       = 9'd366;
  localparam logic [3:0]  FEBRUARY        = 4'd2;
  localparam logic [2:0]  WDAY_OFFSET     = 3'd4;

  localparam logic [5:0] DIV60 = 6'd60;
  localparam logic [5:0] DIV24 = 6'd24;
  localparam logic [5:0] DIV7  = 6'd7;

  // Reciprocals and the product shift that give an exact quotient over the reachable range.
  localparam logic [31:0] RECIP60 = 32'h8888_8889;
  localparam logic [31:0] RECIP24 = 32'hAAAA_AAAB;
  localparam logic [31:0] RECIP7  = 32'd74899;

  localparam logic [4:0] MONTH_LEN [0:15] = '{
    5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
  };

  typedef enum logic [2:0] {
    OP_LOAD, OP_MUL, OP_QUO, OP_REM, OP_INIT, OP_YEAR, OP_MONTH, OP_EMIT
  } op_t;

  typedef enum logic [1:0] {SEL_DIV60, SEL_DIV24, SEL_DIV7} sel_t;

  typedef enum logic [1:0] {DST_SEC, DST_MIN, DST_HOUR, DST_WDAY} dst_t;

  typedef enum logic [2:0] {
    C_NEVER, C_NO_INPUT, C_YEAR_GE, C_MONTH_GE, C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t             op;
    sel_t            sel;
    dst_t            dst;
    logic            ld_quo;
    cond_t           cond;
    logic            last;
    logic [PC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_busy;
    logic year_ge;
    logic month_ge;
  } status_t;

  typedef struct packed {
    logic [11:0] year_number;
    logic [3:0]  month_number;
    logic [4:0]  day_of_month;
    logic [2:0]  weekday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } date_t;

  localparam logic [PC_W-1:0] PC_IDLE  = 5'd0;
  localparam logic [PC_W-1:0] PC_YEAR  = 5'd14;
  localparam logic [PC_W-1:0] PC_MONTH = 5'd15;
  localparam logic [PC_W-1:0] PC_EMIT  = 5'd16;

  function automatic ctrl_t cw(op_t op, sel_t sel, dst_t dst, logic ld_quo, cond_t cond,
                               logic last, logic [PC_W-1:0] target);
    ctrl_t w;
    w.op     = op;
    w.sel    = sel;
    w.dst    = dst;
    w.ld_quo = ld_quo;
    w.cond   = cond;
    w.last   = last;
    w.target = target;
    return w;
  endfunction

  function automatic ctrl_t prog_word(logic [PC_W-1:0] pc);
    ctrl_t w;
    case (pc)
      5'd0:    w = cw(OP_LOAD,  SEL_DIV60, DST_SEC,  1'b0, C_NO_INPUT, 1'b0, PC_IDLE);
      5'd1:    w = cw(OP_MUL,   SEL_DIV60, DST_SEC,  1'b0, C_NEVER,    1'b0, PC_IDLE);
      5'd2:    w = cw(OP_QUO,   SEL_DIV60, DST_SEC,  1'b0, C_NEVER,    1'b0, PC_IDLE);
      5'd3:    w = cw(OP_REM,   SEL_DIV60, DST_SEC,  1'b1, C_NEVER,    1'b0, PC_IDLE);
      5'd4:    w = cw(OP_MUL,   SEL_DIV60, DST_MIN,  1'b0, C_NEVER,    1'b0, PC_IDLE);
      5'd5:    w = cw(OP_QUO,   SEL_DIV60, DST_MIN,  1'b0, C_NEVER,    1'b0, PC_IDLE);
      5'd6:    w = cw(OP_REM,   SEL_DIV60, DST_MIN,  1'b1, C_NEVER,    1'b0, PC_IDLE);
      5'd7:    w = cw(OP_MUL,   SEL_DIV24, DST_HOUR, 1'b0, C_NEVER,    1'b0, PC_IDLE);
      5'd8:    w = cw(OP_QUO,   SEL_DIV24, DST_HOUR, 1'b0, C_NEVER,    1'b0, PC_IDLE);
      5'd9:    w = cw(OP_REM,   SEL_DIV24, DST_HOUR, 1'b1, C_NEVER,    1'b0, PC_IDLE);
      5'd10:   w = cw(OP_MUL,   SEL_DIV7,  DST_WDAY, 1'b0, C_NEVER,    1'b0, PC_IDLE);
      5'd11:   w = cw(OP_QUO,   SEL_DIV7,  DST_WDAY, 1'b0, C_NEVER,    1'b0, PC_IDLE);
      5'd12:   w = cw(OP_REM,   SEL_DIV7,  DST_WDAY, 1'b0, C_NEVER,    1'b0, PC_IDLE);
      5'd13:   w = cw(OP_INIT,  SEL_DIV60, DST_SEC,  1'b0, C_NEVER,    1'b0, PC_IDLE);
      5'd14:   w = cw(OP_YEAR,  SEL_DIV60, DST_SEC,  1'b0, C_YEAR_GE,  1'b0, PC_YEAR);
      5'd15:   w = cw(OP_MONTH, SEL_DIV60, DST_SEC,  1'b0, C_MONTH_GE, 1'b0, PC_MONTH);
      5'd16:   w = cw(OP_EMIT,  SEL_DIV60, DST_SEC,  1'b0, C_OUT_BUSY, 1'b1, PC_EMIT);
      default: w = cw(OP_LOAD,  SEL_DIV60, DST_SEC,  1'b0, C_NO_INPUT, 1'b0, PC_IDLE);
    endcase
    return w;
  endfunction

endpackage

// File: hw/rtl/ucd_sequencer.sv
// Step counter and microprogram lookup with conditional jumps.
`timescale 1ns / 1ps

module ucd_sequencer (
  input  logic             clk,
  input  logic             rst_n,
  input  ucd_pkg::status_t status,
  output ucd_pkg::ctrl_t   ctrl
);
  import ucd_pkg::*;

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  logic            take;

  assign ctrl = prog_word(pc_r);

  always_comb begin
    case (ctrl.cond)
      C_NEVER:    take = 1'b0;
      C_NO_INPUT: take = !status.in_valid;
      C_YEAR_GE:  take = status.year_ge;
      C_MONTH_GE: take = status.month_ge;
      C_OUT_BUSY: take = status.out_busy;
      default:    take = 1'b0;
    endcase
    if (take) begin
      pc_nxt = ctrl.target;
    end else if (ctrl.last) begin
      pc_nxt = PC_IDLE;
    end else begin
      pc_nxt = pc_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// File: hw/rtl/ucd_datapath.sv
// Datapath: shared reciprocal multiplier, remainder unit and the year and month steppers.
`timescale 1ns / 1ps

module ucd_datapath (
  input  logic           clk,
  input  ucd_pkg::ctrl_t ctrl,
  input  logic [31:0]    in_seconds,
  input  logic           in_take,
  output logic           year_ge,
  output logic           month_ge,
  output ucd_pkg::date_t date
);
  import ucd_pkg::*;

  logic [31:0] acc_r;
  logic [63:0] prod_r;
  logic [31:0] q_r;
  logic [5:0]  sec_r;
  logic [5:0]  min_r;
  logic [4:0]  hr_r;
  logic [2:0]  wd_r;
  logic [11:0] yr_r;
  logic [3:0]  mo_r;

  logic [31:0] operand;
  logic [31:0] recip;
  logic [5:0]  divisor;
  logic [31:0] quo;
  logic [5:0]  rem;
  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;

  always_comb begin
    case (ctrl.sel)
      SEL_DIV60: begin
        recip   = RECIP60;
        divisor = DIV60;
        quo     = {5'd0, prod_r[63:37]};
      end
      SEL_DIV24: begin
        recip   = RECIP24;
        divisor = DIV24;
        quo     = {4'd0, prod_r[63:36]};
      end
      SEL_DIV7: begin
        recip   = RECIP7;
        divisor = DIV7;
        quo     = prod_r[50:19];
      end
      default: begin
        recip   = RECIP60;
        divisor = DIV60;
        quo     = {5'd0, prod_r[63:37]};
      end
    endcase
  end

  assign operand = (ctrl.sel == SEL_DIV7) ? acc_r + 32'(WDAY_OFFSET) : acc_r;
  assign rem     = operand[5:0] - 6'(q_r[5:0] * divisor);

  // Only 2100 among the reachable century years is not a leap year.
  assign leap     = (yr_r[1:0] == 2'b00) && (yr_r != NONLEAP_CENTURY);
  assign ylen     = leap ? DAYS_LEAP : DAYS_COMMON;
  assign mlen     = MONTH_LEN[mo_r] + 5'((mo_r == FEBRUARY) && leap);
  assign year_ge  = acc_r >= 32'(ylen);
  assign month_ge = (mo_r < LAST_MONTH) && (acc_r >= 32'(mlen));

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LOAD: begin
        if (in_take) begin
          acc_r <= in_seconds;
        end
      end
      OP_MUL: begin
        prod_r <= 64'(operand) * 64'(recip);
      end
      OP_QUO: begin
        q_r <= quo;
      end
      OP_REM: begin
        case (ctrl.dst)
          DST_SEC:  sec_r <= rem;
          DST_MIN:  min_r <= rem;
          DST_HOUR: hr_r  <= rem[4:0];
          DST_WDAY: wd_r  <= rem[2:0] + 3'd1;
          default:  sec_r <= rem;
        endcase
        if (ctrl.ld_quo) begin
          acc_r <= q_r;
        end
      end
      OP_INIT: begin
        yr_r <= EPOCH_YEAR;
        mo_r <= FIRST_MONTH;
      end
      OP_YEAR: begin
        if (year_ge) begin
          acc_r <= acc_r - 32'(ylen);
          yr_r  <= yr_r + 12'd1;
        end
      end
      OP_MONTH: begin
        if (month_ge) begin
          acc_r <= acc_r - 32'(mlen);
          mo_r  <= mo_r + 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

  assign date.year_number  = yr_r;
  assign date.month_number = mo_r;
  assign date.day_of_month = acc_r[4:0] + 5'd1;
  assign date.weekday      = wd_r;
  assign date.hour         = hr_r;
  assign date.minute       = min_r;
  assign date.second       = sec_r;

endmodule

// File: hw/rtl/unix_time_to_calendar_date.sv
// Top level of the Unix time to calendar date converter: stream handshakes and result register.
//
//   Channel  Direction  tdata bits  Contents
//   in_      slave      31:0        seconds_since_epoch
//   out_     master     47:0        second, minute, hour, weekday, day, month, year
//
// The length of a transaction grows with Y, the number of whole years since 1970, and with M,
// the number of whole months into the year.
// The year and month search, one step a cycle in the microprogram, sets this length.
// Reset clears the step counter and the result valid flag.
// A finished result waits in the output register while the next transaction is accepted.
`timescale 1ns / 1ps

module unix_time_to_calendar_date (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] seconds_since_epoch
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // [5:0] second, [11:6] minute, [16:12] hour,
                                  // [19:17] weekday, [24:20] day_of_month,
                                  // [28:25] month_number, [40:29] year_number
);
  import ucd_pkg::*;

  ctrl_t       ctrl;
  status_t     status;
  date_t       date;
  logic        emit;
  logic        out_tvalid_r;
  logic        out_tvalid_nxt;
  logic [47:0] out_tdata_r;

  assign in_tready       = (ctrl.op == OP_LOAD);
  assign status.in_valid = in_tvalid;
  assign status.out_busy = out_tvalid_r && !out_tready;
  assign emit            = (ctrl.op == OP_EMIT) && !status.out_busy;

  ucd_sequencer u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  ucd_datapath u_dp (
    .clk        (clk),
    .ctrl       (ctrl),
    .in_seconds (in_tdata),
    .in_take    (in_tvalid),
    .year_ge    (status.year_ge),
    .month_ge   (status.month_ge),
    .date       (date)
  );

  always_comb begin
    if (emit) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end else begin
      out_tvalid_nxt = out_tvalid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
    if (emit) begin
      out_tdata_r <= {7'd0, date};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted again while a conversion is in progress");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_tvalid)
    else $error("finished conversion did not reach the output register");

  a_no_emit_while_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !emit)
    else $error("result register overwritten while held");

  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[28:25] != 4'd0) && (out_tdata[28:25] <= LAST_MONTH))
    else $error("month out of range");

  a_weekday_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[19:17] != 3'd0))
    else $error("weekday out of range");
`endif

endmodule

// File: tb/unix_time_to_calendar_date_tb.sv
// Self-checking testbench for the Unix time to calendar date converter.
`timescale 1ns / 1ps

import ucd_pkg::date_t;

function automatic bit is_leap_year(int unsigned y);
  return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
endfunction

function automatic int unsigned days_in_year(int unsigned y);
  return is_leap_year(y) ? 366 : 365;
endfunction

function automatic int unsigned month_length(int unsigned y, int unsigned m);
  int unsigned n;
  case (m)
    4, 6, 9, 11: n = 30;
    2:           n = is_leap_year(y) ? 29 : 28;
    default:     n = 31;
  endcase
  return n;
endfunction

class calendar_scoreboard;
  date_t       pending_dates[$];
  int unsigned mismatches;
  int unsigned dates_checked;

  function new();
    mismatches    = 0;
    dates_checked = 0;
  endfunction

  function date_t to_calendar(logic [31:0] secs);
    date_t           d;
    longint unsigned v;
    int unsigned     days;
    int unsigned     yr;
    int unsigned     mo;
    v        = secs;
    d.second = 6'(v % 60);
    v        = v / 60;
    d.minute = 6'(v % 60);
    v        = v / 60;
    d.hour   = 5'(v % 24);
    days     = int'(v / 24);
    d.weekday = 3'((days + 4) % 7 + 1);
    yr = 1970;
    while (days >= days_in_year(yr)) begin
      days -= days_in_year(yr);
      yr++;
    end
    mo = 1;
    while (mo < 12 && days >= month_length(yr, mo)) begin
      days -= month_length(yr, mo);
      mo++;
    end
    d.day_of_month = 5'(days + 1);
    d.month_number = 4'(mo);
    d.year_number  = 12'(yr);
    return d;
  endfunction

  function void note_timestamp(logic [31:0] secs);
    pending_dates.push_back(to_calendar(secs));
  endfunction

  function void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function void check_date(logic [47:0] word);
    date_t want;
    date_t got;
    if (pending_dates.size() == 0) begin
      $error("Result transaction %h arrived with no date outstanding", word);
      mismatches++;
      return;
    end
    want = pending_dates.pop_front();
    got  = date_t'(word[40:0]);
    dates_checked++;
    compare_field("second", want.second, got.second);
    compare_field("minute", want.minute, got.minute);
    compare_field("hour", want.hour, got.hour);
    compare_field("weekday", want.weekday, got.weekday);
    compare_field("day_of_month", want.day_of_month, got.day_of_month);
    compare_field("month_number", want.month_number, got.month_number);
    compare_field("year_number", want.year_number, got.year_number);
    compare_field("padding", 0, word[47:41]);
  endfunction
endclass

module unix_time_to_calendar_date_tb;

  localparam int unsigned RANDOM_ITEMS  = 830;
  localparam int unsigned IDLE_LIMIT    = 4000;
  localparam int unsigned DRAIN_CYCLES  = 200;
  localparam int unsigned HOLD_CYCLES   = 700;
  localparam int unsigned SECS_PER_DAY  = 86400;

  localparam int unsigned N_EDGE = 20;
  localparam logic [31:0] EDGE_TIMES [N_EDGE] = '{
    32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
    32'd68169600, 32'd94694399, 32'd946684799, 32'd951782400, 32'd951868800,
    32'h7FFF_FFFF, 32'h8000_0000, 32'd4102444799, 32'd4107542400,
    32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;

  calendar_scoreboard sb;
  bit                 steady;
  int unsigned        idle_cycles;
  int unsigned        sent;

  unix_time_to_calendar_date uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint month_start_secs(int unsigned y, int unsigned m);
    longint d;
    d = 0;
    for (int unsigned yy = 1970; yy < y; yy++) d += days_in_year(yy);
    for (int unsigned mm = 1; mm < m; mm++) d += month_length(y, mm);
    return d * SECS_PER_DAY;
  endfunction

  task automatic send_timestamp(input logic [31:0] secs);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= secs;
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_timestamp(in_tdata);
      if (out_tvalid && out_tready) sb.check_date(out_tdata);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("unix_time_to_calendar_date verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned received;
    int unsigned gap;
    received = 0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (received == 40 || received == 500) gap = HOLD_CYCLES;
      else gap = steady ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      received++;
    end
  end

  initial begin
    longint      t;
    int unsigned y;
    int unsigned m;
    sb          = new();
    steady      = 1'b0;
    idle_cycles = 0;
    sent        = 0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_EDGE; i++) send_timestamp(EDGE_TIMES[i]);

    // Most random timestamps sit near the year, month and day boundaries.
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 64 == 0) steady = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0: t = $urandom;
        1: begin
          y = $urandom_range(1971, 2106);
          t = month_start_secs(y, 1) - 100 + $urandom_range(0, 200);
        end
        2: begin
          y = $urandom_range(1970, 2105);
          m = $urandom_range(2, 12);
          t = month_start_secs(y, m) - 100 + $urandom_range(0, 200);
        end
        default: begin
          t = longint'($urandom_range(0, 49709)) * SECS_PER_DAY;
          case ($urandom_range(0, 3))
            0: t += 0;
            1: t += SECS_PER_DAY - 1;
            2: t += 3599;
            default: t += $urandom_range(0, SECS_PER_DAY - 1);
          endcase
        end
      endcase
      send_timestamp(32'(t));
    end
    in_tvalid <= 1'b0;

    while (sb.pending_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.pending_dates.size() != 0)
      $error("%0d dates still outstanding at the end", sb.pending_dates.size());
    $display("Sent %0d timestamps and checked %0d dates, covering leap days, century years,",
             sent, sb.dates_checked);
    $display("the 32-bit limit and random stalls on both channels with long output hold-offs.");
    if (sb.mismatches == 0 && sb.pending_dates.size() == 0) begin
      $display("unix_time_to_calendar_date verification clean");
    end else begin
      $display("unix_time_to_calendar_date verification failed");
    end
    $finish;
  end

endmodule
